// File: hdl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types, widths, register indexes and helpers of the color matrix
// converter.
// ----------------------------------------------------------------------------
package ccm_pkg;

	localparam int CH_N       = 3;
	localparam int PIX_W      = 8;
	localparam int COEFF_W    = 14;
	localparam int ROW_W      = CH_N * COEFF_W;
	localparam int DIFF_W     = PIX_W + 1;
	localparam int PROD_W     = DIFF_W + COEFF_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_W     = 11;
	localparam int RND_W      = SUM_W - FRAC_W;
	localparam int VAL_W      = RND_W + 1;
	localparam int PACK_W     = CH_N * PIX_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ROW_W;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_RY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_GU   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_BV   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_OFFS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LO_BOUND   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HI_BOUND   = 3'd6;

	// reset values: identity matrix, no offsets, full clamp range
	localparam logic [ROW_W-1:0]  RST_COEFF_RY = ROW_W'(64'd2048);
	localparam logic [ROW_W-1:0]  RST_COEFF_GU = ROW_W'(64'd33554432);
	localparam logic [ROW_W-1:0]  RST_COEFF_BV = ROW_W'(64'd549755813888);
	localparam logic [PACK_W-1:0] RST_HI_BOUND = '1;

	// rounding constant, one half in Q14.11
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));

	typedef logic [PIX_W-1:0]           pix_t;
	typedef logic signed [COEFF_W-1:0]  coeff_t;
	typedef logic signed [DIFF_W-1:0]   diff_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [VAL_W-1:0]    val_t;

	typedef struct packed {
		logic [CH_N-1:0][ROW_W-1:0] coeff_rows;
		logic [CH_N-1:0][PIX_W-1:0] in_offs;
		logic [CH_N-1:0][PIX_W-1:0] out_offs;
		logic [CH_N-1:0][PIX_W-1:0] lo_bound;
		logic [CH_N-1:0][PIX_W-1:0] hi_bound;
	} ccm_cfg_t;

	// coefficient k of one packed row
	function automatic coeff_t coeff_at(input logic [ROW_W-1:0] row, input int k);
		coeff_t c;
		c = row[k*COEFF_W +: COEFF_W];
		return c;
	endfunction

endpackage

// File: hdl/ccm_pix_if.sv
// ----------------------------------------------------------------------------
// ccm_pix_if
// Pixel channels of the converter: input pixel and converted pixel, each
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccm_in_if;
	logic                valid;
	logic                ready;
	ccm_pkg::pix_t       ry_in;
	ccm_pkg::pix_t       gu_in;
	ccm_pkg::pix_t       bv_in;

	modport source (output valid, ry_in, gu_in, bv_in, input ready);
	modport sink   (input valid, ry_in, gu_in, bv_in, output ready);
endinterface

interface ccm_out_if;
	logic                valid;
	logic                ready;
	ccm_pkg::pix_t       ry_out;
	ccm_pkg::pix_t       gu_out;
	ccm_pkg::pix_t       bv_out;

	modport source (output valid, ry_out, gu_out, bv_out, input ready);
	modport sink   (input valid, ry_out, gu_out, bv_out, output ready);
endinterface

// File: hdl/ccm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ccm_cfg_regs
// Configuration register file: coefficient rows, offsets and clamp bounds,
// written through a plain index/data port.
// ----------------------------------------------------------------------------
module ccm_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ccm_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [ccm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output ccm_pkg::ccm_cfg_t                    cfg
);
	import ccm_pkg::*;

	ccm_cfg_t cfg_q;

	// register writes, out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff_rows[0] <= RST_COEFF_RY;
			cfg_q.coeff_rows[1] <= RST_COEFF_GU;
			cfg_q.coeff_rows[2] <= RST_COEFF_BV;
			cfg_q.in_offs       <= '0;
			cfg_q.out_offs      <= '0;
			cfg_q.lo_bound      <= '0;
			cfg_q.hi_bound      <= RST_HI_BOUND;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COEFF_RY: cfg_q.coeff_rows[0] <= cfg_wdata;
				REG_COEFF_GU: cfg_q.coeff_rows[1] <= cfg_wdata;
				REG_COEFF_BV: cfg_q.coeff_rows[2] <= cfg_wdata;
				REG_IN_OFFS:  cfg_q.in_offs       <= cfg_wdata[PACK_W-1:0];
				REG_OUT_OFFS: cfg_q.out_offs      <= cfg_wdata[PACK_W-1:0];
				REG_LO_BOUND: cfg_q.lo_bound      <= cfg_wdata[PACK_W-1:0];
				REG_HI_BOUND: cfg_q.hi_bound      <= cfg_wdata[PACK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/ccm_mac.sv
// ----------------------------------------------------------------------------
// ccm_mac
// First two pipeline stages: input offset subtraction, then the nine
// coefficient products of the 3x3 matrix.
// ----------------------------------------------------------------------------
module ccm_mac (
	input  logic                                         clk,
	input  logic                                         adv,
	input  ccm_pkg::ccm_cfg_t                            cfg,
	input  logic [ccm_pkg::CH_N-1:0][ccm_pkg::PIX_W-1:0] pix,
	output logic [ccm_pkg::CH_N-1:0][ccm_pkg::CH_N-1:0][ccm_pkg::PROD_W-1:0] prod_s2
);
	import ccm_pkg::*;

	diff_t [CH_N-1:0] diff_s1;
	logic  [CH_N-1:0][CH_N-1:0][PROD_W-1:0] prod_d;

	// stage 1: remove input offsets
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < CH_N; k++) begin
				diff_s1[k] <= $signed({1'b0, pix[k]}) - $signed({1'b0, cfg.in_offs[k]});
			end
		end
	end

	// stage 2: one product per coefficient
	always_comb begin
		for (int ch = 0; ch < CH_N; ch++) begin
			for (int k = 0; k < CH_N; k++) begin
				prod_d[ch][k] = prod_t'($signed(diff_s1[k]))
					* prod_t'(coeff_at(cfg.coeff_rows[ch], k));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

// File: hdl/ccm_round_clamp.sv
// ----------------------------------------------------------------------------
// ccm_round_clamp
// Last two pipeline stages of one output channel: sum of products with
// rounding and output offset, then clamping to the channel bounds.
// ----------------------------------------------------------------------------
module ccm_round_clamp (
	input  logic                                          clk,
	input  logic                                          adv,
	input  logic [ccm_pkg::CH_N-1:0][ccm_pkg::PROD_W-1:0] prod,
	input  ccm_pkg::pix_t                                 out_off,
	input  ccm_pkg::pix_t                                 lo,
	input  ccm_pkg::pix_t                                 hi,
	output ccm_pkg::pix_t                                 res_s4
);
	import ccm_pkg::*;

	logic signed [SUM_W-1:0] sum;
	logic signed [RND_W-1:0] rnd;
	val_t                    val_s3;
	val_t                    lo_v;
	val_t                    hi_v;
	pix_t                    res_d;

	// stage 3: dot product, round half up by floor shift, add output offset
	always_comb begin
		sum = SUM_W'($signed(prod[0])) + SUM_W'($signed(prod[1]))
			+ SUM_W'($signed(prod[2])) + ROUND_HALF;
		rnd = sum[SUM_W-1:FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s3 <= VAL_W'(rnd) + $signed({{(VAL_W-PIX_W){1'b0}}, out_off});
		end
	end

	// stage 4: zero or below and below minimum give minimum, then maximum
	always_comb begin
		lo_v = $signed({{(VAL_W-PIX_W){1'b0}}, lo});
		hi_v = $signed({{(VAL_W-PIX_W){1'b0}}, hi});
		if (val_s3 <= 0 || val_s3 < lo_v) begin
			res_d = lo;
		end else if (val_s3 > hi_v) begin
			res_d = hi;
		end else begin
			res_d = val_s3[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4 <= res_d;
		end
	end

endmodule

// File: hdl/color_matrix_converter_unit.sv
// ----------------------------------------------------------------------------
// color_matrix_converter_unit
// Converts one pixel of three 8-bit components per clock through a
// programmable 3x3 Q3.11 matrix with per-channel input offsets, output
// offsets and clamp bounds. A pixel is taken every cycle while the output
// is not stalled; its result comes out after the four pipeline stages
// (offset subtract, multiply, sum and round, clamp). Input ready stays low
// during reset and until the registered run flag is set after it. When the
// output is stalled the whole pipeline holds, and it moves again as soon as
// the output transaction completes. Registers are written with
// cfg_we/cfg_idx/cfg_wdata and take effect on the next pixel; write them
// only while the pipeline is empty. After reset the matrix is identity,
// offsets are zero and the clamp range is full.
// ----------------------------------------------------------------------------
module color_matrix_converter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ccm_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ccm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	ccm_in_if.sink                          pix_in,
	ccm_out_if.source                       pix_out
);
	import ccm_pkg::*;

	ccm_cfg_t                         cfg;
	logic                             adv;
	logic                             run_q;
	logic                             valid_s1;
	logic                             valid_s2;
	logic                             valid_s3;
	logic                             valid_s4;
	logic [CH_N-1:0][PIX_W-1:0]       pix;
	logic [CH_N-1:0][CH_N-1:0][PROD_W-1:0] prod_s2;
	logic [CH_N-1:0][PIX_W-1:0]       res_s4;

	ccm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// pipeline moves unless a finished result is waiting
	assign adv          = !valid_s4 || pix_out.ready;
	assign pix_in.ready = adv && run_q;

	// valid bits travel with the data, input opens once run_q is set after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			run_q <= 1'b1;
			if (adv) begin
				valid_s1 <= pix_in.valid && run_q;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
			end
		end
	end

	assign pix[0] = pix_in.ry_in;
	assign pix[1] = pix_in.gu_in;
	assign pix[2] = pix_in.bv_in;

	ccm_mac u_mac (
		.clk     (clk),
		.adv     (adv),
		.cfg     (cfg),
		.pix     (pix),
		.prod_s2 (prod_s2)
	);

	// one rounding and clamp slice per output channel
	for (genvar ch = 0; ch < CH_N; ch++) begin : g_chan
		ccm_round_clamp u_rc (
			.clk     (clk),
			.adv     (adv),
			.prod    (prod_s2[ch]),
			.out_off (cfg.out_offs[ch]),
			.lo      (cfg.lo_bound[ch]),
			.hi      (cfg.hi_bound[ch]),
			.res_s4  (res_s4[ch])
		);
	end

	assign pix_out.valid  = valid_s4;
	assign pix_out.ry_out = res_s4[0];
	assign pix_out.gu_out = res_s4[1];
	assign pix_out.bv_out = res_s4[2];

endmodule

// File: verif/color_matrix_converter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_matrix_converter_unit_tb
// Self-checking bench for the color matrix converter. Pixels go in through a
// valid/ready channel with bursty timing. Each converted pixel is compared
// against a local fixed-point model of the matrix, rounding, offsets and
// clamp. The output side stalls on a rotating pattern, at random and once
// for a long hold. Registers are reprogrammed only while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module color_matrix_converter_unit_tb;

	import ccm_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_PIXELS  = 110;
	localparam int HOLD_PIXELS   = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam longint HALF_LSB  = longint'(1) << (FRAC_W - 1);

	// register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam coeff_t Q_ONE = 14'sd2048;
	localparam coeff_t Q_MAX = 14'sh1fff;
	localparam coeff_t Q_MIN = 14'sh2000;

	typedef struct packed {
		pix_t ry;
		pix_t gu;
		pix_t bv;
	} pixel_t;

	typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ccm_in_if  pix_in_bus ();
	ccm_out_if pix_out_bus ();

	color_matrix_converter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in_bus),
		.pix_out   (pix_out_bus)
	);

	// register copy used by the conversion model
	logic [ROW_W-1:0]  coeff_shadow [CH_N];
	logic [PACK_W-1:0] in_offs_shadow;
	logic [PACK_W-1:0] out_offs_shadow;
	logic [PACK_W-1:0] lo_bound_shadow;
	logic [PACK_W-1:0] hi_bound_shadow;

	pixel_t   pending_pixels [$];
	int       error_count = 0;
	int       cycle_count = 0;
	int       sender_burst_left = 0;
	bit       sender_gaps = 1'b1;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_hold_left = 0;
	int       hold_requests = 0;
	int       hold_served = 0;
	logic [12:0] rx_pattern = 13'b1011001110101;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected converted pixel for the current register copy
	function automatic pixel_t convert_pixel(input pixel_t p);
		pix_t   comp [CH_N];
		pix_t   res [CH_N];
		longint diff [CH_N];
		longint acc;
		longint level;
		longint lo;
		longint hi;
		coeff_t coef;
		pixel_t r;
		comp[0] = p.ry;
		comp[1] = p.gu;
		comp[2] = p.bv;
		for (int k = 0; k < CH_N; k++)
			diff[k] = longint'(comp[k]) - longint'(in_offs_shadow[k*PIX_W +: PIX_W]);
		for (int ch = 0; ch < CH_N; ch++) begin
			acc = 0;
			for (int k = 0; k < CH_N; k++) begin
				coef = coeff_shadow[ch][k*COEFF_W +: COEFF_W];
				acc += diff[k] * longint'(coef);
			end
			// arithmetic shift floors the sum plus one half, so ties round up, also for negative sums
			level = ((acc + HALF_LSB) >>> FRAC_W)
				+ longint'(out_offs_shadow[ch*PIX_W +: PIX_W]);
			lo = longint'(lo_bound_shadow[ch*PIX_W +: PIX_W]);
			hi = longint'(hi_bound_shadow[ch*PIX_W +: PIX_W]);
			// zero or below wins first, then below min, then above max
			if (level <= 0)
				level = lo;
			else if (level < lo)
				level = lo;
			else if (level > hi)
				level = hi;
			res[ch] = level[PIX_W-1:0];
		end
		r.ry = res[0];
		r.gu = res[1];
		r.bv = res[2];
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] pack_row(input coeff_t c0, input coeff_t c1,
			input coeff_t c2);
		return {c2, c1, c0};
	endfunction

	// 24-bit register value with junk above the register width
	function automatic logic [CFG_DATA_W-1:0] with_stray_bits(input logic [PACK_W-1:0] v);
		logic [CFG_DATA_W-PACK_W-1:0] junk;
		junk = (CFG_DATA_W-PACK_W)'($urandom);
		return {junk, v};
	endfunction

	function automatic pix_t random_component();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.ry = random_component();
		p.gu = random_component();
		p.bv = random_component();
		return p;
	endfunction

	function automatic coeff_t random_coeff();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4: return coeff_t'(int'($urandom_range(0, 4096)) - 2048);
			default: return coeff_t'($urandom);
		endcase
	endfunction

	// register write, cfg_we is dropped again before the task returns
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_COEFF_RY: coeff_shadow[0] = data[ROW_W-1:0];
			REG_COEFF_GU: coeff_shadow[1] = data[ROW_W-1:0];
			REG_COEFF_BV: coeff_shadow[2] = data[ROW_W-1:0];
			REG_IN_OFFS:  in_offs_shadow  = data[PACK_W-1:0];
			REG_OUT_OFFS: out_offs_shadow = data[PACK_W-1:0];
			REG_LO_BOUND: lo_bound_shadow = data[PACK_W-1:0];
			REG_HI_BOUND: hi_bound_shadow = data[PACK_W-1:0];
			default: ; // no register here, write is dropped
		endcase
	endtask

	// one input transaction, with bursts and gaps in front of it
	task automatic send_pixel(input pixel_t p);
		int gap;
		if (sender_burst_left <= 0) begin
			gap = 0;
			if (sender_gaps)
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16)
					: $urandom_range(0, 4);
			if (gap > 0) begin
				pix_in_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			sender_burst_left = sender_gaps ? $urandom_range(1, 20) : 1 << 30;
		end
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.ry_in <= p.ry;
		pix_in_bus.gu_in <= p.gu;
		pix_in_bus.bv_in <= p.bv;
		@(posedge clk);
		while (!pix_in_bus.ready) @(posedge clk);
		pending_pixels.push_back(convert_pixel(p));
		sender_burst_left--;
	endtask

	// stop sending and let the pipeline empty
	task automatic drain_pipeline();
		pix_in_bus.valid <= 1'b0;
		sender_burst_left = 0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixels(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(random_pixel());
	endtask

	task automatic write_random_settings();
		logic [PACK_W-1:0] lo;
		logic [PACK_W-1:0] hi;
		write_register(REG_COEFF_RY, pack_row(random_coeff(), random_coeff(), random_coeff()));
		write_register(REG_COEFF_GU, pack_row(random_coeff(), random_coeff(), random_coeff()));
		write_register(REG_COEFF_BV, pack_row(random_coeff(), random_coeff(), random_coeff()));
		write_register(REG_IN_OFFS, with_stray_bits(PACK_W'($urandom)));
		write_register(REG_OUT_OFFS, with_stray_bits(PACK_W'($urandom)));
		// mostly a sane window, sometimes any bounds at all
		if ($urandom_range(0, 4) == 0) begin
			lo = PACK_W'($urandom);
			hi = PACK_W'($urandom);
		end else begin
			for (int ch = 0; ch < CH_N; ch++) begin
				lo[ch*PIX_W +: PIX_W] = pix_t'($urandom_range(0, 60));
				hi[ch*PIX_W +: PIX_W] = pix_t'($urandom_range(180, 255));
			end
		end
		write_register(REG_LO_BOUND, with_stray_bits(lo));
		write_register(REG_HI_BOUND, with_stray_bits(hi));
		if ($urandom_range(0, 2) == 0)
			write_register(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
	endtask

	// identity matrix and full range straight out of reset
	task automatic test_reset_defaults();
		send_pixel('{ry: 8'h00, gu: 8'h00, bv: 8'h00});
		send_pixel('{ry: 8'hff, gu: 8'hff, bv: 8'hff});
		send_pixel('{ry: 8'haa, gu: 8'h55, bv: 8'h0f});
		send_pixel('{ry: 8'h55, gu: 8'haa, bv: 8'hf0});
		drain_pipeline();
	endtask

	// fractional negative sums, sums at or below zero, dropped and wide writes
	task automatic test_rounding_and_zero_clamp();
		write_register(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
		write_register(REG_COEFF_RY, pack_row(coeff_t'(-3072), '0, '0));
		write_register(REG_COEFF_GU, pack_row('0, coeff_t'(-1024), '0));
		write_register(REG_COEFF_BV, pack_row(Q_MAX, Q_MAX, Q_MIN));
		write_register(REG_IN_OFFS, with_stray_bits({8'd128, 8'd0, 8'd0}));
		write_register(REG_OUT_OFFS, with_stray_bits({8'd0, 8'd10, 8'd10}));
		write_register(REG_LO_BOUND, with_stray_bits({8'd7, 8'd3, 8'd5}));
		write_register(REG_HI_BOUND, with_stray_bits({8'd200, 8'd255, 8'd250}));
		send_pixel('{ry: 8'd1, gu: 8'd1, bv: 8'd0});
		send_pixel('{ry: 8'd0, gu: 8'd3, bv: 8'd0});
		send_pixel('{ry: 8'd200, gu: 8'd2, bv: 8'd128});
		send_pixel('{ry: 8'd255, gu: 8'd255, bv: 8'd255});
		send_pixel('{ry: 8'd0, gu: 8'd0, bv: 8'd255});
		send_pixel('{ry: 8'd255, gu: 8'd255, bv: 8'd0});
		drain_pipeline();
	endtask

	// lower bound above upper bound
	task automatic test_inverted_clamp();
		write_register(REG_COEFF_RY, pack_row(Q_ONE, '0, '0));
		write_register(REG_COEFF_GU, pack_row('0, Q_ONE, '0));
		write_register(REG_COEFF_BV, pack_row('0, '0, Q_ONE));
		write_register(REG_IN_OFFS, '0);
		write_register(REG_OUT_OFFS, '0);
		write_register(REG_LO_BOUND, {3{8'd200}});
		write_register(REG_HI_BOUND, {3{8'd50}});
		send_pixel('{ry: 8'd0, gu: 8'd0, bv: 8'd0});
		send_pixel('{ry: 8'd100, gu: 8'd199, bv: 8'd200});
		send_pixel('{ry: 8'd250, gu: 8'd255, bv: 8'd201});
		drain_pipeline();
	endtask

	// largest and most negative coefficients with full offsets
	task automatic test_coefficient_extremes();
		write_register(REG_COEFF_RY, pack_row(Q_MAX, Q_MAX, Q_MAX));
		write_register(REG_COEFF_GU, pack_row(Q_MIN, Q_MIN, Q_MIN));
		write_register(REG_COEFF_BV, pack_row(Q_MAX, Q_MIN, Q_ONE));
		write_register(REG_IN_OFFS, {CFG_DATA_W{1'b1}});
		write_register(REG_OUT_OFFS, {CFG_DATA_W{1'b1}});
		write_register(REG_LO_BOUND, '0);
		write_register(REG_HI_BOUND, {CFG_DATA_W{1'b1}});
		send_pixel('{ry: 8'hff, gu: 8'hff, bv: 8'hff});
		send_pixel('{ry: 8'h00, gu: 8'h00, bv: 8'h00});
		send_pixel('{ry: 8'h00, gu: 8'hff, bv: 8'h00});
		send_pixel('{ry: 8'hff, gu: 8'h00, bv: 8'hff});
		drain_pipeline();
	endtask

	// random pixels across many settings and output stall styles
	task automatic test_random_settings();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					write_register(REG_COEFF_RY, pack_row(Q_MAX, Q_MAX, Q_MAX));
					write_register(REG_COEFF_GU, pack_row(Q_MAX, Q_MAX, Q_MAX));
					write_register(REG_COEFF_BV, pack_row(Q_MAX, Q_MAX, Q_MAX));
					write_register(REG_IN_OFFS, {3{8'hff}});
					write_register(REG_OUT_OFFS, {3{8'hff}});
					write_register(REG_LO_BOUND, '0);
					write_register(REG_HI_BOUND, {3{8'hff}});
				end
				1: begin
					write_register(REG_COEFF_RY, pack_row(Q_MIN, Q_MIN, Q_MIN));
					write_register(REG_COEFF_GU, pack_row(Q_MIN, Q_MIN, Q_MIN));
					write_register(REG_COEFF_BV, pack_row(Q_MIN, Q_MIN, Q_MIN));
					write_register(REG_IN_OFFS, '0);
					write_register(REG_OUT_OFFS, '0);
					write_register(REG_LO_BOUND, {3{8'hff}});
					write_register(REG_HI_BOUND, '0);
				end
				default: write_random_settings();
			endcase
			rx_mode     = rx_mode_t'(phase % 3);
			sender_gaps = (phase % 4 != 3);
			send_pixels(PHASE_PIXELS);
			drain_pipeline();
		end
		rx_mode     = RX_RANDOM;
		sender_gaps = 1'b1;
	endtask

	// long output hold while the sender keeps pushing
	task automatic test_output_backpressure();
		write_random_settings();
		sender_gaps = 1'b0;
		rx_mode     = RX_PATTERN;
		hold_requests++;
		send_pixels(HOLD_PIXELS);
		drain_pipeline();
		sender_gaps = 1'b1;
	endtask

	// output side ready: long hold first, then the current stall style
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_out_bus.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			pix_out_bus.ready <= 1'b0;
			rx_hold_left <= HOLD_CYCLES;
			hold_served  <= hold_requests;
		end else if (rx_hold_left > 0) begin
			pix_out_bus.ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			case (rx_mode)
				RX_FREE: pix_out_bus.ready <= 1'b1;
				RX_PATTERN: begin
					pix_out_bus.ready <= rx_pattern[0];
					rx_pattern <= {rx_pattern[0], rx_pattern[12:1]};
				end
				default: pix_out_bus.ready <= ($urandom_range(0, 9) >= 3);
			endcase
		end
	end

	task automatic check_component(input string name, input pix_t want, input pix_t got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// compare each output transaction with the oldest expected pixel
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected output transaction: %0d %0d %0d",
					pix_out_bus.ry_out, pix_out_bus.gu_out, pix_out_bus.bv_out);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_component("ry_out", want.ry, pix_out_bus.ry_out);
				check_component("gu_out", want.gu, pix_out_bus.gu_out);
				check_component("bv_out", want.bv, pix_out_bus.bv_out);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_idx           <= '0;
		cfg_wdata         <= '0;
		pix_in_bus.valid  <= 1'b0;
		pix_in_bus.ry_in  <= '0;
		pix_in_bus.gu_in  <= '0;
		pix_in_bus.bv_in  <= '0;
		coeff_shadow[0] = RST_COEFF_RY;
		coeff_shadow[1] = RST_COEFF_GU;
		coeff_shadow[2] = RST_COEFF_BV;
		in_offs_shadow  = '0;
		out_offs_shadow = '0;
		lo_bound_shadow = '0;
		hi_bound_shadow = RST_HI_BOUND;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_mode = RX_RANDOM;
		test_reset_defaults();
		test_rounding_and_zero_clamp();
		test_inverted_clamp();
		test_coefficient_extremes();
		test_random_settings();
		test_output_backpressure();

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
hdl/ccm_pkg.sv
hdl/ccm_pix_if.sv
hdl/ccm_cfg_regs.sv
hdl/ccm_mac.sv
hdl/ccm_round_clamp.sv
hdl/color_matrix_converter_unit.sv
verif/color_matrix_converter_unit_tb.sv
